// File: src/lzwd_pkg.sv
// Shared types, constants and the preset window pattern for the LZ77 window decoder.
`timescale 1ns / 1ps

package lzwd_pkg;

  localparam int unsigned WIN_AW    = 12;
  localparam int unsigned WIN_DEPTH = 4096;
  localparam int unsigned CNT_W     = 5;

  // Requests from the sequencer to the history window.
  typedef struct packed {
    logic              clear;
    logic              rd_en;
    logic [WIN_AW-1:0] rd_addr;
    logic              wr_en;
    logic [WIN_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
  } win_req_t;

  // Decoder sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_CTRL = 5'b00001,
    S_LIT  = 5'b00010,
    S_OFS  = 5'b00100,
    S_RD   = 5'b01000,
    S_WR   = 5'b10000
  } seq_state_t;

  // Contents of a window entry that has not been written since the last restart.
  function automatic logic [7:0] preset_byte(input logic [WIN_AW-1:0] addr);
    logic [WIN_AW-1:0] rel;
    logic [7:0]        val;
    rel = addr - 12'h200;
    if (addr[11:8] == 4'h0) begin
      val = addr[7:0];
    end else if (addr[11:8] == 4'h1) begin
      val = ~addr[7:0];
    end else if (addr < 12'h600) begin
      val = rel[9:2];
    end else begin
      val = addr[7:0];
    end
    return val;
  endfunction

endpackage

// File: src/lz77_window_decoder_core.sv
// Top level of the LZ77 window decoder: stream ports, decode sequencer and output register.
`timescale 1ns / 1ps

// A literal data byte is registered in the output register as it is accepted and shows
// on the output in the cycle after. Each match byte is read from memory in S_RD, then
// written back and output in S_WR, which holds while the output stalls; a match copies
// 3 to 17 bytes, taking no input. Match throughput is set by the read-then-write
// order: the next source byte may be the one just written back by the same match.
// Reset (synchronous, active low) clears pointers, counters and the sequencer; the window
// reads as the preset pattern through a fill count, so no clearing pass is needed.
module lz77_window_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  // Input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] action: 1 = restart with preset dictionary
  // Output stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  localparam int unsigned AW = lzwd_pkg::WIN_AW;
  localparam int unsigned CW = lzwd_pkg::CNT_W;

  lzwd_pkg::seq_state_t state_r, state_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] cp_r, cp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    held_r, held_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;

  logic          out_free;
  logic          accept;
  logic [7:0]    win_rd_data;

  lzwd_pkg::win_req_t win_req;

  // The output register may be refilled in the same cycle that its word is taken.
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    unique case (state_r)
      lzwd_pkg::S_CTRL: in_tready = 1'b1;
      lzwd_pkg::S_OFS:  in_tready = 1'b1;
      lzwd_pkg::S_LIT:  in_tready = out_free;
      default:          in_tready = 1'b0;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    cp_nxt        = cp_r;
    cnt_nxt       = cnt_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    win_req         = '0;
    win_req.rd_addr = cp_r;
    win_req.wr_addr = wp_r;
    win_req.wr_data = in_tdata;

    if (accept && in_tuser) begin
      // Restart: drop all decode state and bring the window back to the preset.
      win_req.clear = 1'b1;
      state_nxt     = lzwd_pkg::S_CTRL;
      wp_nxt        = '0;
      cp_nxt        = '0;
      cnt_nxt       = '0;
      held_nxt      = '0;
    end else begin
      unique case (state_r)
        lzwd_pkg::S_CTRL: begin
          if (accept) begin
            held_nxt = in_tdata;
            if (in_tdata[7:4] == 4'h0) begin
              cnt_nxt   = CW'(in_tdata[3:0]) + CW'(1);
              state_nxt = lzwd_pkg::S_LIT;
            end else begin
              cnt_nxt   = CW'(in_tdata[7:4]) + CW'(2);
              state_nxt = lzwd_pkg::S_OFS;
            end
          end
        end
        lzwd_pkg::S_LIT: begin
          if (accept) begin
            win_req.wr_en = 1'b1;
            wp_nxt        = wp_r + 1'b1;
            out_valid_nxt = 1'b1;
            out_byte_nxt  = in_tdata;
            out_last_nxt  = 1'b1;
            cnt_nxt       = cnt_r - 1'b1;
            if (cnt_r == CW'(1)) begin
              state_nxt = lzwd_pkg::S_CTRL;
            end
          end
        end
        lzwd_pkg::S_OFS: begin
          if (accept) begin
            cp_nxt    = {held_r[3:0], in_tdata};
            cnt_nxt   = CW'(held_r[7:4]) + CW'(2);
            state_nxt = lzwd_pkg::S_RD;
          end
        end
        lzwd_pkg::S_RD: begin
          win_req.rd_en = 1'b1;
          cp_nxt        = cp_r + 1'b1;
          state_nxt     = lzwd_pkg::S_WR;
        end
        lzwd_pkg::S_WR: begin
          // Read data stays registered in the window until the next read,
          // so a stalled output simply holds this state.
          if (out_free) begin
            win_req.wr_en   = 1'b1;
            win_req.wr_data = win_rd_data;
            wp_nxt          = wp_r + 1'b1;
            out_valid_nxt   = 1'b1;
            out_byte_nxt    = win_rd_data;
            out_last_nxt    = (cnt_r == CW'(1));
            cnt_nxt         = cnt_r - 1'b1;
            state_nxt       = (cnt_r == CW'(1)) ? lzwd_pkg::S_CTRL : lzwd_pkg::S_RD;
          end
        end
        default: begin
          state_nxt = lzwd_pkg::S_CTRL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzwd_pkg::S_CTRL;
      wp_r        <= '0;
      cp_r        <= '0;
      cnt_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      cp_r        <= cp_nxt;
      cnt_r       <= cnt_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  lzwd_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (win_req),
    .rd_data (win_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

// File: src/lzwd_window.sv
// History window: 4096-byte synchronous memory with a fill count that stands in for the preset.
`timescale 1ns / 1ps

module lzwd_window (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lzwd_pkg::win_req_t      req,
  output logic [7:0]              rd_data
);

  logic [7:0]                 mem [lzwd_pkg::WIN_DEPTH];
  logic [7:0]                 mem_q_r;
  logic [7:0]                 preset_q_r;
  logic                       hit_r;
  logic [lzwd_pkg::WIN_AW:0]  fill_r;
  logic [lzwd_pkg::WIN_AW:0]  fill_nxt;

  // Writes after a restart run strictly upward from address zero, so every
  // entry below the fill count holds written data and the rest hold the preset.
  always_comb begin
    fill_nxt = fill_r;
    if (req.clear) begin
      fill_nxt = '0;
    end else if (req.wr_en && !fill_r[lzwd_pkg::WIN_AW]) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mem_q_r    <= mem[req.rd_addr];
      preset_q_r <= lzwd_pkg::preset_byte(req.rd_addr);
      hit_r      <= ({1'b0, req.rd_addr} < fill_r);
    end
  end

  assign rd_data = hit_r ? mem_q_r : preset_q_r;

endmodule
